// ===== rtl/mbox_pkg.sv =====
// shared types, constants and pattern lookups for the unread message counter
// no dependencies; used by every module under rtl

package mbox_pkg;

	// operation codes on the input channel
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_BYTE   = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	// special byte values
	localparam logic [7:0] BYTE_LF    = 8'h0A;
	localparam logic [7:0] BYTE_CR    = 8'h0D;
	localparam logic [7:0] BYTE_R     = "R";
	localparam logic [7:0] BYTE_O     = "O";
	localparam logic [7:0] BYTE_ZERO  = "0";

	// line position tracking
	localparam int LINE_POS_W = 5;
	localparam int POS_MAX    = 31;

	// prefix lengths and end of the four flag digits
	localparam int FROM_LEN   = 5;
	localparam int STATUS_LEN = 8;
	localparam int LONG_LEN   = 18;
	localparam int FLAGS_END  = 22;

	localparam logic [8*FROM_LEN-1:0]   PAT_FROM   = "From ";
	localparam logic [8*STATUS_LEN-1:0] PAT_STATUS = "Status: ";
	// long status prefix, mail client name spelt out as bytes
	localparam logic [8*LONG_LEN-1:0]   PAT_LONG   = {"X-", 8'h4D, 8'h6F, 8'h7A, 8'h69,
		8'h6C, 8'h6C, 8'h61, "-Status: "};

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic [1:0] {
		CMD_START,
		CMD_BYTE,
		CMD_EOL,
		CMD_FINISH
	} cmd_kind_t;

	// classified item handed from front to back
	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
		logic        resume;
		logic        grew;
		logic        is_ro;
		logic        is_zero;
	} cmd_t;

	function automatic logic [7:0] from_char(input logic [LINE_POS_W-1:0] pos);
		logic [7:0] c;
		c = 8'h00;
		for (int i = 0; i < FROM_LEN; i++) begin
			if (pos == LINE_POS_W'(i)) c = PAT_FROM[8*(FROM_LEN-1-i) +: 8];
		end
		return c;
	endfunction

	function automatic logic [7:0] status_char(input logic [LINE_POS_W-1:0] pos);
		logic [7:0] c;
		c = 8'h00;
		for (int i = 0; i < STATUS_LEN; i++) begin
			if (pos == LINE_POS_W'(i)) c = PAT_STATUS[8*(STATUS_LEN-1-i) +: 8];
		end
		return c;
	endfunction

	function automatic logic [7:0] long_char(input logic [LINE_POS_W-1:0] pos);
		logic [7:0] c;
		c = 8'h00;
		for (int i = 0; i < LONG_LEN; i++) begin
			if (pos == LINE_POS_W'(i)) c = PAT_LONG[8*(LONG_LEN-1-i) +: 8];
		end
		return c;
	endfunction

endpackage

// ===== rtl/mbox_front.sv =====
// front end: accepts input transfers, decodes the operation and classifies bytes
// depends on mbox_pkg

module mbox_front (
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       operation,
	input  logic [7:0]       data_byte,
	input  logic             resume_appended,
	input  logic             file_grew,
	output logic             push_valid,
	input  logic             push_ready,
	output mbox_pkg::cmd_t   push_cmd
);

	logic keep;

	always_comb begin
		keep = 1'b1;
		push_cmd.kind = mbox_pkg::CMD_BYTE;
		unique case (operation)
			mbox_pkg::OP_START:  push_cmd.kind = mbox_pkg::CMD_START;
			mbox_pkg::OP_FINISH: push_cmd.kind = mbox_pkg::CMD_FINISH;
			mbox_pkg::OP_BYTE: begin
				if (data_byte == mbox_pkg::BYTE_LF) push_cmd.kind = mbox_pkg::CMD_EOL;
				else if (data_byte == mbox_pkg::BYTE_CR) keep = 1'b0;
			end
			default: keep = 1'b0;
		endcase
		push_cmd.data    = data_byte;
		push_cmd.resume  = resume_appended;
		push_cmd.grew    = file_grew;
		push_cmd.is_ro   = (data_byte == mbox_pkg::BYTE_R) || (data_byte == mbox_pkg::BYTE_O);
		push_cmd.is_zero = (data_byte == mbox_pkg::BYTE_ZERO);
	end

	// dropped items (cr, unused code) still need a free slot so order is kept simple
	assign in_ready   = push_ready;
	assign push_valid = in_valid && keep;

endmodule

// ===== rtl/mbox_queue.sv =====
// short fifo of classified commands between front and back
// depends on mbox_pkg

module mbox_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  mbox_pkg::cmd_t   push_cmd,
	output logic             head_valid,
	input  logic             pop,
	output mbox_pkg::cmd_t   head_cmd
);

	localparam int DEPTH = mbox_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	mbox_pkg::cmd_t  slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== rtl/mbox_back.sv =====
// back end: line and header tracking, unread count and the result register
// depends on mbox_pkg

module mbox_back #(
	parameter int COUNT_WIDTH = mbox_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  mbox_pkg::cmd_t         head_cmd,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [COUNT_WIDTH-1:0] unread_count,
	output logic                   suppressed
);

	localparam int PW = mbox_pkg::LINE_POS_W;

	logic [PW-1:0]          line_pos_q, line_pos_d;
	logic                   from_ok_q, from_ok_d;
	logic                   status_ok_q, status_ok_d;
	logic                   long_ok_q, long_ok_d;
	logic                   read_seen_q, read_seen_d;
	logic                   zero_ok_q, zero_ok_d;
	logic                   inside_q, inside_d;
	logic                   new_q, new_d;
	logic [COUNT_WIDTH-1:0] running_q, running_d;
	logic [COUNT_WIDTH-1:0] last_q, last_d;
	logic                   out_valid_q;
	logic [COUNT_WIDTH-1:0] unread_count_q;
	logic                   suppressed_q;
	logic                   finish_pop;
	logic                   clear_line;
	logic [7:0]             b;

	assign b          = head_cmd.data;
	assign pop        = head_valid && ((head_cmd.kind != mbox_pkg::CMD_FINISH) ||
		!out_valid_q || out_ready);
	assign finish_pop = pop && (head_cmd.kind == mbox_pkg::CMD_FINISH);

	always_comb begin
		line_pos_d  = line_pos_q;
		from_ok_d   = from_ok_q;
		status_ok_d = status_ok_q;
		long_ok_d   = long_ok_q;
		read_seen_d = read_seen_q;
		zero_ok_d   = zero_ok_q;
		inside_d    = inside_q;
		new_d       = new_q;
		running_d   = running_q;
		last_d      = last_q;
		clear_line  = 1'b0;
		if (pop) begin
			unique case (head_cmd.kind)
				mbox_pkg::CMD_START: begin
					clear_line = 1'b1;
					inside_d   = 1'b0;
					new_d      = 1'b0;
					running_d  = head_cmd.resume ? last_q : '0;
				end
				mbox_pkg::CMD_BYTE: begin
					if (line_pos_q < PW'(mbox_pkg::FROM_LEN) &&
						b != mbox_pkg::from_char(line_pos_q)) from_ok_d = 1'b0;
					if (line_pos_q < PW'(mbox_pkg::STATUS_LEN)) begin
						if (b != mbox_pkg::status_char(line_pos_q)) status_ok_d = 1'b0;
					end else if (status_ok_q && head_cmd.is_ro) begin
						read_seen_d = 1'b1;
					end
					if (line_pos_q < PW'(mbox_pkg::LONG_LEN)) begin
						if (b != mbox_pkg::long_char(line_pos_q)) long_ok_d = 1'b0;
					end else if (line_pos_q < PW'(mbox_pkg::FLAGS_END)) begin
						if (!head_cmd.is_zero) zero_ok_d = 1'b0;
					end
					if (line_pos_q != PW'(mbox_pkg::POS_MAX)) line_pos_d = line_pos_q + 1'b1;
				end
				mbox_pkg::CMD_EOL: begin
					clear_line = 1'b1;
					priority if (!inside_q) begin
						if (line_pos_q >= PW'(mbox_pkg::FROM_LEN) && from_ok_q) begin
							inside_d = 1'b1;
							new_d    = 1'b1;
						end
					end else if (line_pos_q == '0) begin
						// blank line closes the header
						inside_d = 1'b0;
						if (new_q && running_q != '1) running_d = running_q + 1'b1;
					end else if (line_pos_q >= PW'(mbox_pkg::STATUS_LEN) && status_ok_q) begin
						if (read_seen_q) new_d = 1'b0;
					end else if (line_pos_q >= PW'(mbox_pkg::LONG_LEN) && long_ok_q) begin
						if (!(line_pos_q >= PW'(mbox_pkg::FLAGS_END) && zero_ok_q)) new_d = 1'b0;
					end else begin
						new_d = new_q;
					end
				end
				mbox_pkg::CMD_FINISH: begin
					clear_line = 1'b1;
					inside_d   = 1'b0;
					new_d      = 1'b0;
					if (head_cmd.grew && running_q <= last_q) last_d = '0;
					else last_d = running_q;
				end
			endcase
		end
		if (clear_line) begin
			line_pos_d  = '0;
			from_ok_d   = 1'b1;
			status_ok_d = 1'b1;
			long_ok_d   = 1'b1;
			read_seen_d = 1'b0;
			zero_ok_d   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pos_q  <= '0;
			from_ok_q   <= 1'b1;
			status_ok_q <= 1'b1;
			long_ok_q   <= 1'b1;
			read_seen_q <= 1'b0;
			zero_ok_q   <= 1'b1;
			inside_q    <= 1'b0;
			new_q       <= 1'b0;
			running_q   <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			line_pos_q  <= line_pos_d;
			from_ok_q   <= from_ok_d;
			status_ok_q <= status_ok_d;
			long_ok_q   <= long_ok_d;
			read_seen_q <= read_seen_d;
			zero_ok_q   <= zero_ok_d;
			inside_q    <= inside_d;
			new_q       <= new_d;
			running_q   <= running_d;
			last_q      <= last_d;
			if (finish_pop)     out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded only when a finish is carried out
	always_ff @(posedge clk) begin
		if (finish_pop) begin
			if (head_cmd.grew && running_q <= last_q) begin
				unread_count_q <= '0;
				suppressed_q   <= 1'b1;
			end else begin
				unread_count_q <= running_q;
				suppressed_q   <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign unread_count = unread_count_q;
	assign suppressed   = suppressed_q;

	a_finish_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		finish_pop |=> out_valid_q)
		else $error("finish carried out without a result");

	a_finish_clears_scan: assert property (@(posedge clk) disable iff (!arst_n)
		finish_pop |=> (!inside_q && !new_q && line_pos_q == '0))
		else $error("header state survives a finish");

	a_fresh_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_cmd.kind == mbox_pkg::CMD_START && !head_cmd.resume) |=> running_q == '0)
		else $error("fresh start did not clear the count");

	a_suppressed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && suppressed_q) |-> unread_count_q == '0)
		else $error("suppressed result carries a non-zero count");

	a_byte_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_cmd.kind == mbox_pkg::CMD_BYTE) |=> line_pos_q != '0)
		else $error("line byte left the position at zero");

endmodule

// ===== rtl/mbox_unread_message_counter.sv =====
// top level of the mbox unread message counter
// depends on mbox_pkg, mbox_front, mbox_queue and mbox_back
//
// usage:
//  - input channel (in_valid/in_ready) carries one item per transfer: operation
//    selects start of scan, one mailbox byte, or finish; data_byte goes with a
//    byte, resume_appended with a start, file_grew with a finish
//  - output channel (out_valid/out_ready) carries one result per finish:
//    unread_count and suppressed (count forced to zero by the growth check)
//  - throughput: one item per cycle, sustained, while results are taken
//  - a finish transfer with the queue empty writes the queue, the back end then pops
//    it and loads the result register, which shows the result; items ahead in the
//    queue hold a finish back until they have been popped
//  - start and byte items produce no result; cr bytes and the unused
//    operation code are taken and dropped
//  - reset clears the line/header state, running count and last reported
//    count; no result is pending after reset
//  - a receiver stall holds the result register and stops only finish items
//    in the back end; bytes and starts keep flowing, a later finish waits at
//    the head of the two-entry queue, one more item fills it, then in_ready drops

module mbox_unread_message_counter #(
	parameter int COUNT_WIDTH = mbox_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             operation,
	input  logic [7:0]             data_byte,
	input  logic                   resume_appended,
	input  logic                   file_grew,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [COUNT_WIDTH-1:0] unread_count,
	output logic                   suppressed
);

	// front to queue
	logic           push_valid;
	logic           push_ready;
	mbox_pkg::cmd_t push_cmd;

	// queue to back
	logic           head_valid;
	logic           pop;
	mbox_pkg::cmd_t head_cmd;

	// decode and classify each transfer
	mbox_front u_front (
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.data_byte       (data_byte),
		.resume_appended (resume_appended),
		.file_grew       (file_grew),
		.push_valid      (push_valid),
		.push_ready      (push_ready),
		.push_cmd        (push_cmd)
	);

	// decouples acceptance from execution
	mbox_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.head_valid (head_valid),
		.pop        (pop),
		.head_cmd   (head_cmd)
	);

	// prefix matching, header tracking, counting and the result register
	mbox_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_cmd     (head_cmd),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.unread_count (unread_count),
		.suppressed   (suppressed)
	);

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the mbox unread message counter
// depends on rtl/mbox_pkg.sv and rtl/mbox_unread_message_counter.sv

module tb_top;

	localparam int COUNT_W = mbox_pkg::COUNT_WIDTH_DEF;
	localparam logic [COUNT_W-1:0] COUNT_TOP = {COUNT_W{1'b1}};
	localparam int PAT_W = 8 * mbox_pkg::LONG_LEN;
	// operation code the block has no use for, taken and dropped
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               supp;
	} report_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] operation;
	logic [7:0] data_byte;
	logic resume_appended;
	logic file_grew;
	logic out_valid;
	logic out_ready;
	logic [COUNT_W-1:0] unread_count;
	logic suppressed;

	// shadow of the scanner state, updated on every accepted input transfer
	logic [mbox_pkg::LINE_POS_W-1:0] line_pos;
	logic from_ok, status_ok, long_ok, ro_seen, zeros_ok;
	logic in_hdr, msg_new;
	logic [COUNT_W-1:0] count_now, count_last;

	// results still owed by the block, oldest first
	report_t reports_due[$];

	// traffic shaping shared by sender, receiver and tests
	bit idle_on = 1'b1;
	int hold_left = 0;

	// run statistics
	int items_sent = 0;
	int reports_issued = 0;
	int results_seen = 0;
	int suppressed_seen = 0;
	int stall_cycles = 0;
	int mismatches = 0;
	int peak_count = 0;

	mbox_unread_message_counter #(
		.COUNT_WIDTH(COUNT_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.data_byte(data_byte),
		.resume_appended(resume_appended),
		.file_grew(file_grew),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.unread_count(unread_count),
		.suppressed(suppressed)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// byte idx of a prefix held left-aligned in a packed vector of len bytes
	function automatic logic [7:0] pat_char(input logic [PAT_W-1:0] pat, input int len,
		input int idx);
		return pat[8*(len-1-idx) +: 8];
	endfunction

	function automatic void wipe_line();
		line_pos = '0;
		from_ok = 1'b1;
		status_ok = 1'b1;
		long_ok = 1'b1;
		ro_seen = 1'b0;
		zeros_ok = 1'b1;
	endfunction

	function automatic void wipe_header();
		wipe_line();
		in_hdr = 1'b0;
		msg_new = 1'b0;
	endfunction

	// ordinary line byte: track the three prefixes and what follows them
	function automatic void absorb_byte(input logic [7:0] b);
		if (line_pos < mbox_pkg::FROM_LEN && b != pat_char(PAT_W'(mbox_pkg::PAT_FROM),
			mbox_pkg::FROM_LEN, int'(line_pos)))
			from_ok = 1'b0;
		if (line_pos < mbox_pkg::STATUS_LEN) begin
			if (b != pat_char(PAT_W'(mbox_pkg::PAT_STATUS), mbox_pkg::STATUS_LEN,
				int'(line_pos)))
				status_ok = 1'b0;
		end else if (status_ok && (b == mbox_pkg::BYTE_R || b == mbox_pkg::BYTE_O)) begin
			ro_seen = 1'b1;
		end
		if (line_pos < mbox_pkg::LONG_LEN) begin
			if (b != pat_char(mbox_pkg::PAT_LONG, mbox_pkg::LONG_LEN, int'(line_pos)))
				long_ok = 1'b0;
		end else if (line_pos < mbox_pkg::FLAGS_END && b != mbox_pkg::BYTE_ZERO) begin
			zeros_ok = 1'b0;
		end
		if (line_pos < mbox_pkg::POS_MAX)
			line_pos++;
	endfunction

	// line feed: act on the finished line, then start a fresh one
	function automatic void close_line();
		if (!in_hdr) begin
			if (line_pos >= mbox_pkg::FROM_LEN && from_ok) begin
				in_hdr = 1'b1;
				msg_new = 1'b1;
			end
		end else if (line_pos == 0) begin
			in_hdr = 1'b0;
			if (msg_new && count_now != COUNT_TOP)
				count_now++;
		end else if (line_pos >= mbox_pkg::STATUS_LEN && status_ok) begin
			if (ro_seen)
				msg_new = 1'b0;
		end else if (line_pos >= mbox_pkg::LONG_LEN && long_ok) begin
			// short flag field or any non-zero digit means read
			if (!(line_pos >= mbox_pkg::FLAGS_END && zeros_ok))
				msg_new = 1'b0;
		end
		wipe_line();
	endfunction

	function automatic void tally_item(input logic [1:0] op, input logic [7:0] b,
		input logic res, input logic grew);
		report_t rep;
		case (op)
			mbox_pkg::OP_START: begin
				wipe_header();
				count_now = res ? count_last : '0;
			end
			mbox_pkg::OP_BYTE: begin
				if (b == mbox_pkg::BYTE_LF)
					close_line();
				else if (b != mbox_pkg::BYTE_CR)
					absorb_byte(b);
			end
			mbox_pkg::OP_FINISH: begin
				wipe_header();
				// growth without a rise in the count reports zero
				if (grew && count_now <= count_last) begin
					count_last = '0;
					rep.count = '0;
					rep.supp = 1'b1;
				end else begin
					count_last = count_now;
					rep.count = count_now;
					rep.supp = 1'b0;
				end
				reports_due.push_back(rep);
				reports_issued++;
			end
			default: begin
				// spare code changes nothing
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------

	// gap before the next transfer: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// offer one item and hold it until the block takes it
	task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic res,
		input logic grew);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		data_byte <= b;
		resume_appended <= res;
		file_grew <= grew;
		@(posedge clk);
		while (!in_ready) begin
			stall_cycles++;
			@(posedge clk);
		end
		tally_item(op, b, res, grew);
		if (op != OP_SPARE)
			items_sent++;
	endtask

	// unused fields carry random values so their bits toggle too
	task automatic send_byte(input logic [7:0] b);
		send_item(mbox_pkg::OP_BYTE, b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	task automatic send_start(input logic res);
		send_item(mbox_pkg::OP_START, 8'($urandom_range(0, 255)), res,
			1'($urandom_range(0, 1)));
	endtask

	task automatic send_finish(input logic grew);
		send_item(mbox_pkg::OP_FINISH, 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)), grew);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_lf();
		send_byte(mbox_pkg::BYTE_LF);
	endtask

	// line end, sometimes as cr lf
	task automatic send_eol();
		if ($urandom_range(0, 4) == 0)
			send_byte(mbox_pkg::BYTE_CR);
		send_lf();
	endtask

	// long status prefix; spoil names one byte whose 0x20 bit is flipped, -1 for none
	task automatic send_long_prefix(input int spoil);
		logic [7:0] c;
		for (int i = 0; i < mbox_pkg::LONG_LEN; i++) begin
			c = pat_char(mbox_pkg::PAT_LONG, mbox_pkg::LONG_LEN, i);
			if (i == spoil)
				c = c ^ 8'h20;
			send_byte(c);
		end
	endtask

	task automatic send_printable(input int n);
		repeat (n) send_byte(8'($urandom_range(32, 126)));
	endtask

	task automatic send_header_line();
		string letters;
		int n;
		letters = "ROUNx ";
		case ($urandom_range(0, 5))
			0: begin
				send_text("Status: ");
				n = $urandom_range(0, 3);
				repeat (n) send_byte(letters[$urandom_range(0, 5)]);
			end
			1: begin
				// flag digits, mostly zero, sometimes too few or too many
				send_long_prefix(-1);
				n = $urandom_range(0, 6);
				repeat (n) send_byte(($urandom_range(0, 4) == 0) ?
					8'($urandom_range(49, 57)) : mbox_pkg::BYTE_ZERO);
			end
			2: begin
				// near misses on the prefixes
				case ($urandom_range(0, 2))
					0: send_text("Status:R");
					1: send_text("Statu: R");
					default: begin
						send_long_prefix($urandom_range(0, mbox_pkg::LONG_LEN - 1));
						send_text("1");
					end
				endcase
			end
			3: send_text("Subject: hi");
			4: send_printable($urandom_range(20, 40));
			default: begin
				n = $urandom_range(0, 5);
				repeat (n) begin
					logic [7:0] b;
					b = 8'($urandom_range(0, 255));
					send_byte((b == mbox_pkg::BYTE_LF) ? mbox_pkg::BYTE_CR : b);
				end
			end
		endcase
		send_eol();
	endtask

	// one message: envelope line, a few header lines, usually a blank line, short body
	task automatic send_message();
		int n;
		case ($urandom_range(0, 9))
			0: send_text("From");
			1: send_text(" From x");
			2: send_text("Fro m");
			default: begin
				send_text("From ");
				send_printable($urandom_range(0, 3));
			end
		endcase
		send_eol();
		n = $urandom_range(0, 3);
		repeat (n) send_header_line();
		if ($urandom_range(0, 9) != 0)
			send_eol();
		n = $urandom_range(0, 2);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: send_text(">From x");
				1: send_text("From here");
				default: send_printable($urandom_range(0, 12));
			endcase
			send_eol();
		end
	endtask

	// ------------------------------------------------------------------
	// receiver side
	// ------------------------------------------------------------------

	// hold_left forces a long stall, otherwise random stalls while idling is on
	initial begin
		int stall;
		int r;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!idle_on) begin
				out_ready <= 1'b1;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					out_ready <= 1'b1;
				end else if (r < 95) begin
					out_ready <= 1'b0;
					stall = $urandom_range(0, 3);
				end else begin
					out_ready <= 1'b0;
					stall = $urandom_range(15, 50);
				end
			end
		end
	end

	task automatic log_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	// each output transfer against the oldest outstanding report
	always @(posedge clk) begin : check_results
		report_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (suppressed)
				suppressed_seen++;
			if (int'(unread_count) > peak_count)
				peak_count = int'(unread_count);
			if (reports_due.size() == 0) begin
				log_mismatch("result with none outstanding", 0, 1);
			end else begin
				want = reports_due.pop_front();
				if (unread_count !== want.count)
					log_mismatch("unread_count", int'(want.count), int'(unread_count));
				if (suppressed !== want.supp)
					log_mismatch("suppressed", int'(want.supp), int'(suppressed));
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// line handling, with bytes sent before any start
	task automatic test_line_rules();
		// cr dropped inside the envelope line
		send_text("From x");
		send_byte(mbox_pkg::BYTE_CR);
		send_lf();
		send_text("Status: O");
		send_lf();
		// byte extremes on an ordinary header line
		send_byte(8'h00);
		send_byte(8'hFF);
		send_lf();
		send_lf();
		// long status value cut short marks the message read
		send_text("From ");
		send_lf();
		send_long_prefix(-1);
		send_text("00");
		send_lf();
		send_lf();
		// all-zero flags leave it unread
		send_text("From ");
		send_lf();
		send_long_prefix(-1);
		send_text("0000");
		send_lf();
		send_lf();
		send_item(OP_SPARE, 8'hFF, 1'b1, 1'b1);
		// unterminated last line is dropped by the finish
		send_text("From y");
		send_finish(1'b0);
	endtask

	// count carried across finish, long lines, growth check, resume
	task automatic test_report_rules();
		send_lf();
		send_text("From ");
		send_printable(30);
		send_lf();
		send_lf();
		send_finish(1'b1);
		send_start(1'b1);
		send_finish(1'b1);
		send_start(1'b0);
		send_finish(1'b0);
	endtask

	// receiver holds off while finishes keep coming, so the input stalls
	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_left = 300;
		for (int i = 0; i < 12; i++) begin
			send_finish(1'($urandom_range(0, 1)));
			send_byte(mbox_pkg::BYTE_LF);
		end
		@(negedge clk);
		in_valid <= 1'b0;
		while (hold_left > 0 || reports_due.size() != 0)
			@(posedge clk);
		idle_on = 1'b1;
	endtask

	// several unread messages, bytes after a finish with no new start, resume
	task automatic test_count_carry();
		send_start(1'b0);
		repeat (6) begin
			send_text("From ");
			send_lf();
			send_lf();
		end
		send_finish(1'b1);
		// no start: the count keeps rising from where it was
		repeat (4) begin
			send_text("From ");
			send_lf();
			send_lf();
		end
		send_finish(1'b1);
		// resume with nothing new, growth without a rise
		send_start(1'b1);
		send_finish(1'b1);
		// resume after a suppressed report starts from zero
		send_start(1'b1);
		send_text("From ");
		send_lf();
		send_lf();
		send_finish(1'b0);
	endtask

	// whole scans of random mailboxes with noise and broken lines mixed in
	task automatic test_random_mailbox();
		int base_items;
		int base_reports;
		int n;
		base_items = items_sent;
		base_reports = reports_issued;
		while (items_sent - base_items < 1300 || reports_issued - base_reports < 40) begin
			// now and then a stretch with no idling on either side
			idle_on = ($urandom_range(0, 5) != 0);
			if ($urandom_range(0, 4) != 0)
				send_start(1'($urandom_range(0, 1)));
			n = $urandom_range(0, 2);
			repeat (n) send_message();
			case ($urandom_range(0, 9))
				0: begin
					n = $urandom_range(1, 12);
					repeat (n) send_byte(8'($urandom_range(0, 255)));
				end
				1: send_text("From z");
				2: send_item(OP_SPARE, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				default: begin
				end
			endcase
			send_finish(1'($urandom_range(0, 1)));
		end
		idle_on = 1'b1;
	endtask

	initial begin
		int w;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = mbox_pkg::OP_START;
		data_byte = 8'h00;
		resume_appended = 1'b0;
		file_grew = 1'b0;
		wipe_header();
		count_now = '0;
		count_last = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_line_rules();
		test_report_rules();
		test_backpressure();
		test_count_carry();
		test_random_mailbox();

		@(negedge clk);
		in_valid <= 1'b0;
		// drain, bounded well past the longest receiver stall
		for (w = 0; w < 5000 && reports_due.size() != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (reports_due.size() != 0) begin
			mismatches++;
			$display("%0d results never arrived", reports_due.size());
		end

		$display("summary: %0d input transfers, %0d results checked, %0d suppressed",
			items_sent, results_seen, suppressed_seen);
		$display("summary: %0d input stall cycles, highest count reported %0d",
			stall_cycles, peak_count);
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#60_000_000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
